// ===== design/osq_pkg.sv =====
// Shared types and constants for the 1-Wire temperature sensor sequencer.
`timescale 1ns / 1ps

package osq_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESOLUTION = 2'd2;

    localparam logic [7:0] ALARM_HIGH_RST = 8'h32;
    localparam logic [7:0] ALARM_LOW_RST  = 8'h85;
    localparam logic [7:0] RESOLUTION_RST = 8'h7F;

    // sensor ROM / function commands
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCR   = 8'hBE;
    localparam logic [7:0] CMD_WRITE_SCR  = 8'h4E;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_CONFIG  = 2'd1,
        OP_READ    = 2'd2,
        OP_ACK     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        BUS_NONE   = 3'd0,
        BUS_RESET  = 3'd1,
        BUS_WRITE  = 3'd2,
        BUS_RDBIT  = 3'd3,
        BUS_RDBYTE = 3'd4
    } bus_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       link_idle;
        logic       presence_ok;
        logic       sampled_bit;
        logic [7:0] received_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         bus_command;
        logic [7:0]         command_byte;
        logic signed [15:0] temperature;
        logic               reading_ready;
        logic               error_latched;
        logic               busy_res;
    } out_item_t;

endpackage

// ===== design/osq_core.sv =====
// Sequencer state, scratchpad store, config registers and per-request next-state logic.
`timescale 1ns / 1ps

module osq_core #(
    parameter int SCRATCH_BYTES = 9
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [osq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [osq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               step,
    input  osq_pkg::in_item_t                  item,
    output osq_pkg::out_item_t                 result
);

    typedef enum logic [3:0] {
        ST_INIT     = 4'd0,
        ST_IDLE     = 4'd1,
        ST_PRESENCE = 4'd2,
        ST_SKIPROM  = 4'd3,
        ST_CFG_PRE  = 4'd4,
        ST_CFG_AH   = 4'd5,
        ST_CFG_AL   = 4'd6,
        ST_CFG_RES  = 4'd7,
        ST_CONVERT  = 4'd8,
        ST_POLL     = 4'd9,
        ST_RDSP     = 4'd10,
        ST_ACQ      = 4'd11,
        ST_ERROR    = 4'd12
    } state_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_CONFIG    = 3'd1,
        EV_READ      = 3'd2,
        EV_CONVDONE  = 3'd3,
        EV_TEMPREADY = 3'd4
    } event_t;

    localparam logic [3:0] LAST_COUNT = 4'(SCRATCH_BYTES);

    state_t     state_reg, state_next;
    event_t     pending_reg, pending_next;
    logic [3:0] byte_index_reg, byte_index_next;
    logic [7:0] scratch_reg [SCRATCH_BYTES];
    logic [7:0] scratch_next [SCRATCH_BYTES];
    logic [7:0] alarm_high_reg, alarm_low_reg, resolution_reg;

    logic       store_en;
    logic [3:0] index_inc;
    logic [2:0] cmd;
    logic [7:0] cbyte;

    always_comb
    begin
        state_next      = state_reg;
        pending_next    = pending_reg;
        byte_index_next = byte_index_reg;
        store_en        = 1'b0;
        index_inc       = byte_index_reg;
        cmd             = osq_pkg::BUS_NONE;
        cbyte           = 8'h00;

        case (osq_pkg::op_t'(item.op))
            osq_pkg::OP_TICK:
            begin
                case (state_reg)
                    ST_INIT:
                    begin
                        state_next = ST_IDLE;
                    end
                    ST_IDLE:
                    begin
                        if (pending_reg == EV_CONFIG || pending_reg == EV_READ)
                        begin
                            cmd        = osq_pkg::BUS_RESET;
                            state_next = ST_PRESENCE;
                        end
                    end
                    ST_PRESENCE:
                    begin
                        if (item.link_idle)
                        begin
                            if (item.presence_ok)
                            begin
                                cmd        = osq_pkg::BUS_WRITE;
                                cbyte      = osq_pkg::CMD_SKIP_ROM;
                                state_next = ST_SKIPROM;
                            end
                            else
                            begin
                                state_next = ST_ERROR;
                            end
                        end
                    end
                    ST_SKIPROM:
                    begin
                        if (item.link_idle)
                        begin
                            if (pending_reg == EV_CONFIG)
                            begin
                                cmd        = osq_pkg::BUS_WRITE;
                                cbyte      = osq_pkg::CMD_WRITE_SCR;
                                state_next = ST_CFG_PRE;
                            end
                            else if (pending_reg == EV_READ)
                            begin
                                cmd        = osq_pkg::BUS_WRITE;
                                cbyte      = osq_pkg::CMD_CONVERT;
                                state_next = ST_CONVERT;
                            end
                            else if (pending_reg == EV_CONVDONE)
                            begin
                                cmd        = osq_pkg::BUS_WRITE;
                                cbyte      = osq_pkg::CMD_READ_SCR;
                                state_next = ST_RDSP;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    ST_CFG_PRE:
                    begin
                        if (item.link_idle)
                        begin
                            cmd        = osq_pkg::BUS_WRITE;
                            cbyte      = alarm_high_reg;
                            state_next = ST_CFG_AH;
                        end
                    end
                    ST_CFG_AH:
                    begin
                        if (item.link_idle)
                        begin
                            cmd        = osq_pkg::BUS_WRITE;
                            cbyte      = alarm_low_reg;
                            state_next = ST_CFG_AL;
                        end
                    end
                    ST_CFG_AL:
                    begin
                        if (item.link_idle)
                        begin
                            cmd        = osq_pkg::BUS_WRITE;
                            cbyte      = resolution_reg;
                            state_next = ST_CFG_RES;
                        end
                    end
                    ST_CFG_RES:
                    begin
                        if (item.link_idle)
                        begin
                            pending_next = EV_NONE;
                            state_next   = ST_IDLE;
                        end
                    end
                    ST_CONVERT:
                    begin
                        if (item.link_idle)
                        begin
                            cmd        = osq_pkg::BUS_RDBIT;
                            state_next = ST_POLL;
                        end
                    end
                    ST_POLL:
                    begin
                        if (item.link_idle)
                        begin
                            if (item.sampled_bit)
                            begin
                                pending_next = EV_CONVDONE;
                                cmd          = osq_pkg::BUS_RESET;
                                state_next   = ST_PRESENCE;
                            end
                            else
                            begin
                                state_next = ST_CONVERT;
                            end
                        end
                    end
                    ST_RDSP:
                    begin
                        if (item.link_idle)
                        begin
                            byte_index_next = 4'd0;
                            cmd             = osq_pkg::BUS_RDBYTE;
                            state_next      = ST_ACQ;
                        end
                    end
                    ST_ACQ:
                    begin
                        if (item.link_idle)
                        begin
                            // out-of-range index finishes the read without storing
                            if (byte_index_reg < LAST_COUNT)
                            begin
                                store_en  = 1'b1;
                                index_inc = byte_index_reg + 4'd1;
                            end
                            if (index_inc < LAST_COUNT)
                            begin
                                cmd             = osq_pkg::BUS_RDBYTE;
                                byte_index_next = index_inc;
                            end
                            else
                            begin
                                pending_next    = EV_TEMPREADY;
                                byte_index_next = 4'd0;
                                state_next      = ST_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        // error and unused codes hold
                        state_next = state_reg;
                    end
                endcase
            end
            osq_pkg::OP_CONFIG:
            begin
                pending_next = EV_CONFIG;
            end
            osq_pkg::OP_READ:
            begin
                if (pending_reg == EV_NONE)
                begin
                    pending_next = EV_READ;
                end
            end
            osq_pkg::OP_ACK:
            begin
                if (pending_reg == EV_TEMPREADY)
                begin
                    pending_next = EV_NONE;
                end
            end
            default:
            begin
                pending_next = pending_reg;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < SCRATCH_BYTES; i++)
        begin
            scratch_next[i] = (store_en && byte_index_reg == 4'(i)) ?
                              item.received_byte : scratch_reg[i];
        end
    end

    always_comb
    begin
        result.bus_command   = cmd;
        result.command_byte  = cbyte;
        result.temperature   = {scratch_next[1], scratch_next[0]};
        result.reading_ready = (pending_next == EV_TEMPREADY);
        result.error_latched = (state_next == ST_ERROR);
        result.busy_res      = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            pending_reg    <= EV_NONE;
            byte_index_reg <= 4'd0;
            alarm_high_reg <= osq_pkg::ALARM_HIGH_RST;
            alarm_low_reg  <= osq_pkg::ALARM_LOW_RST;
            resolution_reg <= osq_pkg::RESOLUTION_RST;
            for (int i = 0; i < SCRATCH_BYTES; i++)
            begin
                scratch_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (step)
            begin
                state_reg      <= state_next;
                pending_reg    <= pending_next;
                byte_index_reg <= byte_index_next;
                for (int i = 0; i < SCRATCH_BYTES; i++)
                begin
                    scratch_reg[i] <= scratch_next[i];
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    osq_pkg::REG_ALARM_HIGH: alarm_high_reg <= cfg_data;
                    osq_pkg::REG_ALARM_LOW:  alarm_low_reg  <= cfg_data;
                    osq_pkg::REG_RESOLUTION: resolution_reg <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

endmodule

// ===== design/osq_outbuf.sv =====
// Two-entry result queue between the sequencer and the output channel.
`timescale 1ns / 1ps

module osq_outbuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  osq_pkg::out_item_t push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output osq_pkg::out_item_t out_data
);

    osq_pkg::out_item_t entry_reg [2];
    logic               head_reg, head_next;
    logic [1:0]         count_reg, count_next;
    logic               pop;
    logic               tail;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[head_reg];
    assign pop       = out_valid && !out_stall;
    assign tail      = head_reg ^ count_reg[0];

    always_comb
    begin
        head_next  = head_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail] <= push_data;
        end
    end

endmodule

// ===== design/onewire_temp_sensor_sequencer.sv =====
// Top level of the 1-Wire temperature sensor sequencer.
// Each result is queued at the edge that accepts its request.
// Throughput: one request per cycle; a two-entry result queue keeps the input open
// while one result waits, and in_stall rises only when both entries are held.
// Reset (rst_n, async low) clears state to init, pending event to none, the
// scratchpad to zero, the queue to empty and the config registers to their defaults.
`timescale 1ns / 1ps

module onewire_temp_sensor_sequencer #(
    parameter int SCRATCH_BYTES = 9
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [osq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [osq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  osq_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output osq_pkg::out_item_t              out_data
);

    logic               accept;
    osq_pkg::out_item_t result;

    assign accept = in_valid && !in_stall;

    osq_core #(
        .SCRATCH_BYTES (SCRATCH_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (accept),
        .item      (in_data),
        .result    (result)
    );

    osq_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== design/osq_checker.sv =====
// Port-level assertions for the sequencer, bound to the top level.
`timescale 1ns / 1ps

module osq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input osq_pkg::out_item_t out_data
);

    // stalled result must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // input only backs up when results are pending
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without pending result");

    a_byte_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bus_command != osq_pkg::BUS_WRITE
            |-> out_data.command_byte == 8'h00)
        else $error("command byte set without write command");

    a_error_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_latched |-> out_data.busy_res
            && !out_data.reading_ready)
        else $error("error state reported idle or ready");

endmodule

bind onewire_temp_sensor_sequencer osq_checker u_osq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== sim/onewire_temp_sensor_sequencer_test.sv =====
// Self-checking testbench for the 1-Wire temperature sensor sequencer.
`timescale 1ns / 1ps

class temp_seq_scoreboard;
    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_PRESENCE = 4'd2;
    localparam logic [3:0] S_SKIPROM  = 4'd3;
    localparam logic [3:0] S_CFG_PRE  = 4'd4;
    localparam logic [3:0] S_CFG_AH   = 4'd5;
    localparam logic [3:0] S_CFG_AL   = 4'd6;
    localparam logic [3:0] S_CFG_RES  = 4'd7;
    localparam logic [3:0] S_CONVERT  = 4'd8;
    localparam logic [3:0] S_POLL     = 4'd9;
    localparam logic [3:0] S_RDSP     = 4'd10;
    localparam logic [3:0] S_ACQ      = 4'd11;
    localparam logic [3:0] S_ERROR    = 4'd12;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_CONFIG    = 3'd1;
    localparam logic [2:0] EV_READ      = 3'd2;
    localparam logic [2:0] EV_CONVDONE  = 3'd3;
    localparam logic [2:0] EV_TEMPREADY = 3'd4;

    localparam int SCRATCH_LEN = 9;

    logic [7:0]         alarm_hi;
    logic [7:0]         alarm_lo;
    logic [7:0]         resolution;
    logic [3:0]         seq_st;
    logic [2:0]         evt;
    logic [7:0]         scratch [SCRATCH_LEN];
    logic [3:0]         idx;
    osq_pkg::out_item_t expected_q [$];
    int                 errors;

    function new();
        alarm_hi   = osq_pkg::ALARM_HIGH_RST;
        alarm_lo   = osq_pkg::ALARM_LOW_RST;
        resolution = osq_pkg::RESOLUTION_RST;
        seq_st     = S_INIT;
        evt        = EV_NONE;
        idx        = '0;
        errors     = 0;
        foreach (scratch[i])
            scratch[i] = '0;
    endfunction

    function void set_reg(logic [osq_pkg::CFG_INDEX_W-1:0] index, logic [7:0] value);
        case (index)
            osq_pkg::REG_ALARM_HIGH: alarm_hi = value;
            osq_pkg::REG_ALARM_LOW:  alarm_lo = value;
            osq_pkg::REG_RESOLUTION: resolution = value;
            default: ;
        endcase
    endfunction

    function bit awaiting_presence();
        return seq_st == S_PRESENCE;
    endfunction

    function bit reading_in_progress();
        return evt == EV_READ || evt == EV_CONVDONE;
    endfunction

    function int outstanding();
        return expected_q.size();
    endfunction

    // one tick of the bus sequencer
    function void step_sequencer(input osq_pkg::in_item_t it,
                                 output osq_pkg::bus_cmd_t cmd,
                                 output logic [7:0] cb);
        cmd = osq_pkg::BUS_NONE;
        cb  = '0;
        case (seq_st)
            S_INIT: seq_st = S_IDLE;
            S_IDLE:
                if (evt == EV_CONFIG || evt == EV_READ)
                begin
                    cmd    = osq_pkg::BUS_RESET;
                    seq_st = S_PRESENCE;
                end
            S_PRESENCE:
                if (it.link_idle)
                begin
                    if (it.presence_ok)
                    begin
                        cmd    = osq_pkg::BUS_WRITE;
                        cb     = osq_pkg::CMD_SKIP_ROM;
                        seq_st = S_SKIPROM;
                    end
                    else
                        seq_st = S_ERROR;
                end
            S_SKIPROM:
                if (it.link_idle)
                begin
                    if (evt == EV_CONFIG)
                    begin
                        cmd = osq_pkg::BUS_WRITE; cb = osq_pkg::CMD_WRITE_SCR;
                        seq_st = S_CFG_PRE;
                    end
                    else if (evt == EV_READ)
                    begin
                        cmd = osq_pkg::BUS_WRITE; cb = osq_pkg::CMD_CONVERT;
                        seq_st = S_CONVERT;
                    end
                    else if (evt == EV_CONVDONE)
                    begin
                        cmd = osq_pkg::BUS_WRITE; cb = osq_pkg::CMD_READ_SCR;
                        seq_st = S_RDSP;
                    end
                    else
                        seq_st = S_IDLE;
                end
            S_CFG_PRE:
                if (it.link_idle)
                begin
                    cmd = osq_pkg::BUS_WRITE; cb = alarm_hi; seq_st = S_CFG_AH;
                end
            S_CFG_AH:
                if (it.link_idle)
                begin
                    cmd = osq_pkg::BUS_WRITE; cb = alarm_lo; seq_st = S_CFG_AL;
                end
            S_CFG_AL:
                if (it.link_idle)
                begin
                    cmd = osq_pkg::BUS_WRITE; cb = resolution; seq_st = S_CFG_RES;
                end
            S_CFG_RES:
                if (it.link_idle)
                begin
                    evt    = EV_NONE;
                    seq_st = S_IDLE;
                end
            S_CONVERT:
                if (it.link_idle)
                begin
                    cmd    = osq_pkg::BUS_RDBIT;
                    seq_st = S_POLL;
                end
            S_POLL:
                if (it.link_idle)
                begin
                    if (it.sampled_bit)
                    begin
                        evt    = EV_CONVDONE;
                        cmd    = osq_pkg::BUS_RESET;
                        seq_st = S_PRESENCE;
                    end
                    else
                        seq_st = S_CONVERT;
                end
            S_RDSP:
                if (it.link_idle)
                begin
                    idx    = '0;
                    cmd    = osq_pkg::BUS_RDBYTE;
                    seq_st = S_ACQ;
                end
            S_ACQ:
                if (it.link_idle)
                begin
                    if (idx < SCRATCH_LEN)
                    begin
                        scratch[idx] = it.received_byte;
                        idx = idx + 4'd1;
                    end
                    if (idx < SCRATCH_LEN)
                        cmd = osq_pkg::BUS_RDBYTE;
                    else
                    begin
                        evt    = EV_TEMPREADY;
                        idx    = '0;
                        seq_st = S_IDLE;
                    end
                end
            default: ;   // error and unused codes hold
        endcase
    endfunction

    function void note_request(osq_pkg::in_item_t it);
        osq_pkg::out_item_t e;
        osq_pkg::bus_cmd_t  cmd;
        logic [7:0]         cb;
        cmd = osq_pkg::BUS_NONE;
        cb  = '0;
        case (it.op)
            osq_pkg::OP_TICK:   step_sequencer(it, cmd, cb);
            osq_pkg::OP_CONFIG: evt = EV_CONFIG;
            osq_pkg::OP_READ:   if (evt == EV_NONE) evt = EV_READ;
            default:            if (evt == EV_TEMPREADY) evt = EV_NONE;
        endcase
        e.bus_command   = cmd;
        e.command_byte  = cb;
        e.temperature   = {scratch[1], scratch[0]};
        e.reading_ready = (evt == EV_TEMPREADY);
        e.error_latched = (seq_st == S_ERROR);
        e.busy_res      = (seq_st != S_IDLE);
        expected_q.push_back(e);
    endfunction

    function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(osq_pkg::out_item_t got);
        osq_pkg::out_item_t e;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result %0h, nothing pending", $time, got);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        check_field("bus_command", 16'(e.bus_command), 16'(got.bus_command));
        check_field("command_byte", 16'(e.command_byte), 16'(got.command_byte));
        check_field("temperature", e.temperature, got.temperature);
        check_field("reading_ready", 16'(e.reading_ready), 16'(got.reading_ready));
        check_field("error_latched", 16'(e.error_latched), 16'(got.error_latched));
        check_field("busy_res", 16'(e.busy_res), 16'(got.busy_res));
    endfunction
endclass

module onewire_temp_sensor_sequencer_test;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [osq_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [osq_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    osq_pkg::in_item_t               in_data;
    logic                            out_valid;
    logic                            out_stall;
    osq_pkg::out_item_t              out_data;

    temp_seq_scoreboard sb;
    int                 idle_pct;
    bit                 hold_off_req;

    onewire_temp_sensor_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall = 1'b1;
                repeat (60) @(negedge clk);
                out_stall    = 1'b0;
                hold_off_req = 1'b0;
            end
            else
                out_stall = ($urandom_range(99) < idle_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    function automatic osq_pkg::in_item_t mk(logic [1:0] op, logic idle, logic pres,
                                             logic bit_v, logic [7:0] rx);
        osq_pkg::in_item_t it;
        it.op            = op;
        it.link_idle     = idle;
        it.presence_ok   = pres;
        it.sampled_bit   = bit_v;
        it.received_byte = rx;
        return it;
    endfunction

    // mostly ticks with an idle engine, so read and configure sequences run to the end
    function automatic osq_pkg::in_item_t random_request(bit absence_ok);
        osq_pkg::in_item_t it;
        int                r;
        r = $urandom_range(99);
        if (r < 74)
            it.op = osq_pkg::OP_TICK;
        else if (r < 78)
            it.op = (sb.reading_in_progress() && $urandom_range(9) != 0) ?
                    osq_pkg::OP_TICK : osq_pkg::OP_CONFIG;
        else if (r < 90)
            it.op = osq_pkg::OP_READ;
        else
            it.op = osq_pkg::OP_ACK;
        it.link_idle   = ($urandom_range(99) < 82);
        it.sampled_bit = ($urandom_range(99) < 35);
        if (absence_ok || !sb.awaiting_presence())
            it.presence_ok = 1'($urandom_range(1));
        else
            it.presence_ok = 1'b1;
        case ($urandom_range(4))
            0: it.received_byte = 8'h00;
            1: it.received_byte = 8'hFF;
            2: it.received_byte = 8'h80;
            3: it.received_byte = 8'h7F;
            default: it.received_byte = 8'($urandom_range(255));
        endcase
        return it;
    endfunction

    // called and returns at a falling edge
    task automatic push_request(osq_pkg::in_item_t it);
        in_valid = 1'b1;
        in_data  = it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(it);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [osq_pkg::CFG_INDEX_W-1:0] index, logic [7:0] value);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        sb.set_reg(index, value);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic write_config(logic [7:0] ah, logic [7:0] al, logic [7:0] res);
        write_reg(osq_pkg::REG_ALARM_HIGH, ah);
        write_reg(osq_pkg::REG_ALARM_LOW, al);
        write_reg(osq_pkg::REG_RESOLUTION, res);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_phase(int count, bit absence_ok, int hold_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_off_req = 1'b1;
            if ($urandom_range(99) < idle_pct)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            push_request(random_request(absence_ok));
        end
    endtask

    initial
    begin
        sb           = new();
        idle_pct     = 26;
        hold_off_req = 1'b0;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        write_config(8'hFF, 8'h00, 8'h80);

        // directed: init, idle hold, stray ack, config overriding a read, full config
        // write with engine-busy holds, then a read left to the random part
        push_request(mk(osq_pkg::OP_TICK, 1'b1, 1'b0, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_TICK, 1'b1, 1'b1, 1'b1, 8'hFF));
        push_request(mk(osq_pkg::OP_ACK, 1'b0, 1'b0, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_READ, 1'b1, 1'b1, 1'b1, 8'hFF));
        push_request(mk(osq_pkg::OP_CONFIG, 1'b0, 1'b1, 1'b0, 8'h55));
        push_request(mk(osq_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 8'hAA));
        push_request(mk(osq_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_TICK, 1'b0, 1'b1, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_TICK, 1'b0, 1'b1, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_READ, 1'b1, 1'b1, 1'b0, 8'h00));
        push_request(mk(osq_pkg::OP_READ, 1'b1, 1'b1, 1'b0, 8'h00));

        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                1: write_config(8'h00, 8'h00, 8'h00);
                2: write_config(8'hFF, 8'hFF, 8'hFF);
                4: write_config(osq_pkg::ALARM_HIGH_RST, osq_pkg::ALARM_LOW_RST,
                                osq_pkg::RESOLUTION_RST);
                default: write_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                      8'($urandom_range(255)));
            endcase
            // phase 2 runs with no gaps or stalls on either side
            idle_pct = (p == 2) ? 0 : 26;
            run_phase(210, 1'b0, (p == 1 || p == 4) ? 50 : -1);
        end

        // presence noise at the end: the error state sticks for the rest of the run
        idle_pct = 26;
        run_phase(60, 1'b1, -1);

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
